[rtl/assert_macros.svh]
// Assertion macros used by the top level RTL file of the block pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that a condition is accompanied by a consequence in the same cycle.
`define ASSERT_IMPLIES(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

[rtl/fbpa_pkg.sv]
// Types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned CMP_W = 18;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_BASE    = 3'd1;
  localparam logic [2:0] ST_NOT_CREATED = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd3;
  localparam logic [2:0] ST_NONE_FREE   = 3'd4;
  localparam logic [2:0] ST_IGNORED     = 3'd5;
  localparam logic [2:0] ST_BAD_INDEX   = 3'd6;

  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd1;
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] request_size;
    logic [7:0]  block_index;
    logic        block_present;
  } fbpa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  granted_index;
    logic [31:0] granted_address;
    logic [8:0]  free_blocks;
  } fbpa_rsp_t;

endpackage

[rtl/fbpa_link_ram.sv]
// Link memory of the free list with one write port and one registered read port.
module fbpa_link_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: request decode, free list control and link memory.
//
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             req_i (fbpa_req_t)
// result    out        done_o, one cycle, no stall rsp_o (fbpa_rsp_t)
// config    in         cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// A free or a rejected request is handled when it is accepted and its result beat follows in the next cycle.
// A get also holds the allocator busy in ST_GET while the link memory read of the head block returns.
// A create sweeps the link memory one entry a cycle, then gives its result beat.
// After reset the pool is not created; the link memory needs no clearing pass.
// The receiver cannot stall, so busy depends only on the running request.
`include "assert_macros.svh"

module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  fbpa_req_t   req_i,
  output logic        done_o,
  output fbpa_rsp_t   rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_CREATE
  } state_e;

  state_e            state_q;
  logic              done_q;
  fbpa_rsp_t         rsp_q;
  logic              pool_ready_q;
  logic [IdxW-1:0]   head_q;
  logic [CntW-1:0]   free_q;
  logic [CntW-1:0]   used_count_q;
  logic [15:0]       used_length_q;
  logic [31:0]       used_base_q;
  logic [IdxW-1:0]   sweep_q;

  logic [31:0]       base_cfg_q;
  logic [8:0]        count_cfg_q;
  logic [15:0]       length_cfg_q;

  logic              accept;
  logic              get_ok;
  logic              free_ok;
  logic              sweep_last;
  logic [CMP_W-1:0]  count_ext;
  logic [CntW-1:0]   count_clamped;
  logic [31:0]       grant_addr;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [IdxW-1:0]   ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_cfg_q   <= '0;
      count_cfg_q  <= 9'd256;
      length_cfg_q <= 16'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BASE_ADDRESS: base_cfg_q   <= cfg_data_i;
        REG_BLOCK_COUNT:  count_cfg_q  <= cfg_data_i[8:0];
        REG_BLOCK_LENGTH: length_cfg_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;

  always_comb begin
    count_ext = CMP_W'(count_cfg_q);
    if (count_ext == '0) begin
      count_clamped = CntW'(1);
    end else if (count_ext > CMP_W'(MAX_BLOCKS)) begin
      count_clamped = CntW'(MAX_BLOCKS);
    end else begin
      count_clamped = CntW'(count_cfg_q);
    end
  end

  assign get_ok = pool_ready_q && (req_i.request_size <= used_length_q) && (free_q != '0);
  assign free_ok = pool_ready_q && req_i.block_present
                && (CMP_W'(req_i.block_index) < CMP_W'(used_count_q))
                && (free_q < used_count_q);
  assign sweep_last = (CntW'(sweep_q) + CntW'(1)) == used_count_q;
  assign grant_addr = used_base_q + 32'(32'(head_q) * 32'(used_length_q));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = head_q;
    ram_re    = 1'b0;
    if (state_q == ST_CREATE) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = sweep_last ? '0 : IdxW'(sweep_q + IdxW'(1));
    end else if (accept && req_i.operation == OP_FREE && free_ok) begin
      ram_we    = 1'b1;
      ram_waddr = IdxW'(req_i.block_index);
      ram_wdata = head_q;
    end
    if (accept && req_i.operation == OP_GET && get_ok) begin
      ram_re = 1'b1;
    end
  end

  fbpa_link_ram #(
    .Depth (MAX_BLOCKS),
    .Width (IdxW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      done_q        <= 1'b0;
      rsp_q         <= '0;
      pool_ready_q  <= 1'b0;
      head_q        <= '0;
      free_q        <= '0;
      used_count_q  <= '0;
      used_length_q <= '0;
      used_base_q   <= '0;
      sweep_q       <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            rsp_q             <= '0;
            rsp_q.free_blocks <= 9'(free_q);
            done_q            <= 1'b1;
            case (req_i.operation)
              OP_CREATE: begin
                if (base_cfg_q == '0) begin
                  rsp_q.status <= ST_BAD_BASE;
                end else begin
                  done_q        <= 1'b0;
                  used_base_q   <= base_cfg_q;
                  used_count_q  <= count_clamped;
                  used_length_q <= length_cfg_q;
                  head_q        <= '0;
                  free_q        <= count_clamped;
                  pool_ready_q  <= 1'b1;
                  sweep_q       <= '0;
                  state_q       <= ST_CREATE;
                end
              end
              OP_GET: begin
                if (!pool_ready_q) begin
                  rsp_q.status <= ST_NOT_CREATED;
                end else if (req_i.request_size > used_length_q) begin
                  rsp_q.status <= ST_TOO_LARGE;
                end else if (free_q == '0) begin
                  rsp_q.status <= ST_NONE_FREE;
                end else begin
                  rsp_q.status          <= ST_OK;
                  rsp_q.granted_index   <= 8'(head_q);
                  rsp_q.granted_address <= grant_addr;
                  rsp_q.free_blocks     <= 9'(free_q - CntW'(1));
                  free_q                <= free_q - CntW'(1);
                  state_q               <= ST_GET;
                end
              end
              OP_FREE: begin
                if (!pool_ready_q) begin
                  rsp_q.status <= ST_NOT_CREATED;
                end else if (!req_i.block_present) begin
                  rsp_q.status <= ST_IGNORED;
                end else if (CMP_W'(req_i.block_index) >= CMP_W'(used_count_q)) begin
                  rsp_q.status <= ST_BAD_INDEX;
                end else if (free_q >= used_count_q) begin
                  rsp_q.status <= ST_IGNORED;
                end else begin
                  rsp_q.status      <= ST_OK;
                  rsp_q.free_blocks <= 9'(free_q + CntW'(1));
                  free_q            <= free_q + CntW'(1);
                  head_q            <= IdxW'(req_i.block_index);
                end
              end
              default: begin
                rsp_q.status <= ST_IGNORED;
              end
            endcase
          end
        end
        ST_GET: begin
          head_q  <= ram_rdata;
          state_q <= ST_IDLE;
        end
        ST_CREATE: begin
          if (sweep_last) begin
            rsp_q             <= '0;
            rsp_q.status      <= ST_OK;
            rsp_q.free_blocks <= 9'(used_count_q);
            done_q            <= 1'b1;
            state_q           <= ST_IDLE;
          end else begin
            sweep_q <= sweep_q + IdxW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ASSERT_ALWAYS(a_free_within_count, free_q <= used_count_q,
                 "Free block count exceeds the pool size.")
  `ASSERT_IMPLIES(a_get_result_shown, state_q == ST_GET, done_q && rsp_q.status == ST_OK,
                  "A pending head update has no granted result beat.")
  `ASSERT_IMPLIES(a_head_in_pool,
                  state_q == ST_IDLE && pool_ready_q && free_q != '0,
                  CntW'(head_q) < used_count_q,
                  "The list head names a block outside the pool.")
  `ASSERT_IMPLIES(a_sweep_in_pool, state_q == ST_CREATE, CntW'(sweep_q) < used_count_q,
                  "The create sweep ran past the block count.")

endmodule
